>>> design/x86d_pkg.sv
// Shared types and constants for the x86 subset instruction decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package x86d_pkg;

  localparam logic [3:0] MAX_LENGTH = 4'd15;

  localparam logic [7:0] PFX_LOCK  = 8'hF0;
  localparam logic [7:0] PFX_REPNE = 8'hF2;
  localparam logic [7:0] PFX_REP   = 8'hF3;
  localparam logic [7:0] PFX_CS    = 8'h2E;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3E;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;

  localparam logic [7:0] OP_JMP8   = 8'hEB;
  localparam logic [7:0] OP_ESC    = 8'h0F;
  localparam logic [7:0] OP_ESC_1E = 8'h1E;
  localparam logic [7:0] OP_ENDBR  = 8'hFB;
  localparam logic [7:0] OP_MOVRR  = 8'h89;
  localparam logic [7:0] OP_GRP83  = 8'h83;
  localparam logic [7:0] OP_MOVIMM = 8'hC7;
  localparam logic [4:0] OP_PUSH_HI = 5'b01010;
  localparam logic [4:0] OP_POP_HI  = 5'b01011;

  localparam logic [2:0] REG_SUB = 3'd5;
  localparam logic [2:0] RM_SIB  = 3'd4;
  localparam logic [1:0] MOD_REG = 2'd3;
  localparam logic [1:0] MOD_D8  = 2'd1;

  localparam int PF_LOCK  = 0;
  localparam int PF_REPNE = 1;
  localparam int PF_REP   = 2;
  localparam int PF_NT    = 3;
  localparam int PF_TK    = 4;
  localparam int PF_OPSZ  = 5;
  localparam int PF_ADSZ  = 6;

  typedef enum logic [2:0] {
    SEG_NONE = 3'd0,
    SEG_CS   = 3'd1,
    SEG_SS   = 3'd2,
    SEG_DS   = 3'd3,
    SEG_ES   = 3'd4,
    SEG_FS   = 3'd5,
    SEG_GS   = 3'd6
  } seg_t;

  typedef enum logic [2:0] {
    FORM_UNKNOWN = 3'd0,
    FORM_PUSH    = 3'd1,
    FORM_POP     = 3'd2,
    FORM_JMP8    = 3'd3,
    FORM_ENDBR32 = 3'd4,
    FORM_MOVRR   = 3'd5,
    FORM_SUBIMM8 = 3'd6,
    FORM_MOVIMMD = 3'd7
  } form_t;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_OP0F    = 3'd1,
    PH_OP0F1E  = 3'd2,
    PH_JMPDISP = 3'd3,
    PH_MODRM   = 3'd4,
    PH_IMM8    = 3'd5,
    PH_DISP8   = 3'd6,
    PH_IMM32   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       final_byte;
  } x86d_in_t;

  typedef struct packed {
    logic [31:0]       inst_address;
    logic [3:0]        inst_length;
    logic [2:0]        form;
    logic [2:0]        first_register;
    logic [2:0]        second_register;
    logic [31:0]       immediate;
    logic signed [7:0] displacement;
    logic [6:0]        prefix_flags;
    logic [2:0]        segment_override;
  } x86d_out_t;

endpackage

`default_nettype wire

>>> design/x86_subset_instruction_decoder.sv
// Top level of the x86 subset instruction decoder: input register, decode core,
// result register. Depends on x86d_pkg and x86d_core.
`default_nettype none

// Takes 32-bit x86 code one byte per transaction and sustains one byte per
// clock cycle while the result is not stalled: each byte is held in an input
// register, decoded combinationally against the decode state in x86d_core,
// and an instruction that the byte completes lands in the result register and
// is presented from there. A stalled result holds the byte in
// the input register and stalls the input channel until the result is taken.
// Prefixes, cut-off instructions and the 15-byte cap are handled on the same
// path; bytes that complete nothing give no result. Writing start_address
// restarts decoding at that address and drops any partial instruction; the
// write is taken while the input register is empty.
module x86_subset_instruction_decoder
  import x86d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire x86d_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output x86d_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic      s1_valid_r, s1_valid_nxt;
  x86d_in_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  x86d_out_t out_data_r;
  logic      out_free;
  logic      s1_go;
  logic      in_take;
  logic      cfg_we;
  logic      emit;
  x86d_out_t result;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = (s1_go && emit) || (out_valid_r && out_stall);

  x86d_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_go),
    .step_data (s1_data_r),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_data),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_go && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> design/x86d_core.sv
// Decode state and single-step decode logic: one code byte per enabled cycle.
// Depends on x86d_pkg.
`default_nettype none

module x86d_core
  import x86d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire x86d_in_t    step_data,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_addr,
  output logic             emit,
  output x86d_out_t        result
);

  phase_t      phase_r,   phase_nxt;
  logic [3:0]  count_r,   count_nxt;
  logic [31:0] addr_r,    addr_nxt;
  logic [6:0]  pfx_r,     pfx_nxt;
  logic [2:0]  seg_r,     seg_nxt;
  logic [7:0]  opcode_r,  opcode_nxt;
  logic [7:0]  modrm_r,   modrm_nxt;
  logic [7:0]  disp_r,    disp_nxt;
  logic [31:0] acc_r,     acc_nxt;
  logic [1:0]  nimm_r,    nimm_nxt;

  logic [7:0]  b;
  logic [3:0]  cnt;
  logic [1:0]  md;
  logic [2:0]  rg;
  logic [2:0]  rm;
  logic [31:0] acc_upd;
  logic        done;

  assign b   = step_data.code_byte;
  assign cnt = count_r + 4'd1;
  assign md  = b[7:6];
  assign rg  = b[5:3];
  assign rm  = b[2:0];
  assign acc_upd = acc_r | ({24'd0, b} << {nimm_r, 3'b000});

  always_comb begin
    phase_nxt  = phase_r;
    pfx_nxt    = pfx_r;
    seg_nxt    = seg_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    acc_nxt    = acc_r;
    nimm_nxt   = nimm_r;
    done       = 1'b0;
    result     = '0;
    result.form = FORM_UNKNOWN;

    unique case (phase_r)
      PH_PREFIX: begin
        unique case (b)
          PFX_LOCK:  pfx_nxt[PF_LOCK]  = 1'b1;
          PFX_REPNE: pfx_nxt[PF_REPNE] = 1'b1;
          PFX_REP:   pfx_nxt[PF_REP]   = 1'b1;
          PFX_CS: begin
            seg_nxt = SEG_CS;
            pfx_nxt[PF_NT] = 1'b1;
          end
          PFX_SS:    seg_nxt = SEG_SS;
          PFX_DS: begin
            seg_nxt = SEG_DS;
            pfx_nxt[PF_TK] = 1'b1;
          end
          PFX_ES:    seg_nxt = SEG_ES;
          PFX_FS:    seg_nxt = SEG_FS;
          PFX_GS:    seg_nxt = SEG_GS;
          PFX_OPSZ:  pfx_nxt[PF_OPSZ] = 1'b1;
          PFX_ADSZ:  pfx_nxt[PF_ADSZ] = 1'b1;
          default: begin
            opcode_nxt = b;
            priority if (b[7:3] == OP_PUSH_HI) begin
              done = 1'b1;
              result.form = FORM_PUSH;
              result.first_register = rm;
            end else if (b[7:3] == OP_POP_HI) begin
              done = 1'b1;
              result.form = FORM_POP;
              result.first_register = rm;
            end else if (b == OP_JMP8) begin
              phase_nxt = PH_JMPDISP;
            end else if (b == OP_ESC) begin
              phase_nxt = PH_OP0F;
            end else begin
              phase_nxt = PH_MODRM;
            end
          end
        endcase
      end
      PH_OP0F: begin
        if (b != OP_ESC_1E) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_OP0F1E;
        end
      end
      PH_OP0F1E: begin
        done = 1'b1;
        if (b == OP_ENDBR) begin
          result.form = FORM_ENDBR32;
        end
      end
      PH_JMPDISP: begin
        disp_nxt = b;
        done = 1'b1;
        result.form = FORM_JMP8;
        result.displacement = b;
      end
      PH_MODRM: begin
        modrm_nxt = b;
        priority if (opcode_r == OP_MOVRR && md == MOD_REG) begin
          done = 1'b1;
          result.form = FORM_MOVRR;
          result.first_register = rm;
          result.second_register = rg;
        end else if (opcode_r == OP_GRP83 && md == MOD_REG) begin
          phase_nxt = PH_IMM8;
        end else if (opcode_r == OP_MOVIMM && md == MOD_D8 && rg == 3'd0 && rm != RM_SIB) begin
          phase_nxt = PH_DISP8;
        end else begin
          done = 1'b1;
        end
      end
      PH_IMM8: begin
        done = 1'b1;
        if (modrm_r[5:3] == REG_SUB) begin
          result.form = FORM_SUBIMM8;
          result.first_register = modrm_r[2:0];
          result.immediate = {{24{b[7]}}, b};
        end
      end
      PH_DISP8: begin
        disp_nxt  = b;
        acc_nxt   = '0;
        nimm_nxt  = '0;
        phase_nxt = PH_IMM32;
      end
      PH_IMM32: begin
        acc_nxt = acc_upd;
        if (nimm_r == 2'd3) begin
          done = 1'b1;
          result.form = FORM_MOVIMMD;
          result.first_register = modrm_r[2:0];
          result.immediate = acc_upd;
          result.displacement = disp_r;
        end else begin
          nimm_nxt = nimm_r + 2'd1;
        end
      end
    endcase

    if (!done && (step_data.final_byte || cnt >= MAX_LENGTH)) begin
      done = 1'b1;
      result.form = FORM_UNKNOWN;
      result.first_register = '0;
      result.second_register = '0;
      result.immediate = '0;
      result.displacement = '0;
    end

    result.inst_address = addr_r;
    result.inst_length = cnt;
    result.prefix_flags = pfx_nxt;
    result.segment_override = seg_nxt;

    count_nxt = cnt;
    addr_nxt  = addr_r;
    if (done) begin
      addr_nxt   = addr_r + {28'd0, cnt};
      phase_nxt  = PH_PREFIX;
      count_nxt  = '0;
      pfx_nxt    = '0;
      seg_nxt    = SEG_NONE;
      opcode_nxt = '0;
      modrm_nxt  = '0;
      disp_nxt   = '0;
      acc_nxt    = '0;
      nimm_nxt   = '0;
    end
  end

  assign emit = step_en && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      count_r  <= '0;
      addr_r   <= '0;
      pfx_r    <= '0;
      seg_r    <= SEG_NONE;
      opcode_r <= '0;
      modrm_r  <= '0;
      disp_r   <= '0;
      acc_r    <= '0;
      nimm_r   <= '0;
    end else if (cfg_we) begin
      phase_r  <= PH_PREFIX;
      count_r  <= '0;
      addr_r   <= cfg_addr;
      pfx_r    <= '0;
      seg_r    <= SEG_NONE;
      opcode_r <= '0;
      modrm_r  <= '0;
      disp_r   <= '0;
      acc_r    <= '0;
      nimm_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      pfx_r    <= pfx_nxt;
      seg_r    <= seg_nxt;
      opcode_r <= opcode_nxt;
      modrm_r  <= modrm_nxt;
      disp_r   <= disp_nxt;
      acc_r    <= acc_nxt;
      nimm_r   <= nimm_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/x86d_checker.sv
// Port-level checker for the x86 subset instruction decoder, with its bind.
// Depends on x86d_pkg and x86_subset_instruction_decoder.
`default_nettype none

module x86d_checker
  import x86d_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire x86d_out_t   out_data,
  input wire logic        cfg_ready
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && !cfg_ready))
    else $error("input stalled without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind x86_subset_instruction_decoder x86d_checker u_x86d_checker (.*);

`default_nettype wire
